// ----- design/cmo_pkg.sv -----
// package: types, constants and codes of the message object controller
package cmo_pkg;

    localparam int NUM_OBJECTS = 16;
    localparam int IDX_W = $clog2(NUM_OBJECTS);

    localparam logic [2:0] OP_WR_CTRL = 3'd0;
    localparam logic [2:0] OP_WR_DATA = 3'd1;
    localparam logic [2:0] OP_CLEAR   = 3'd2;
    localparam logic [2:0] OP_READ    = 3'd3;
    localparam logic [2:0] OP_RX      = 3'd4;
    localparam logic [2:0] OP_TX_DONE = 3'd5;
    localparam logic [2:0] OP_SERVICE = 3'd6;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_REF_IRQ = 2'd1;
    localparam logic [1:0] ST_REF_INIT = 2'd2;
    localparam logic [1:0] ST_NO_MATCH = 2'd3;

    localparam logic [1:0] CFG_INIT   = 2'd0;
    localparam logic [1:0] CFG_ENABLE = 2'd1;
    localparam logic [1:0] CFG_MASTER = 2'd2;

    localparam int F_DIR = 0;
    localparam int F_MSGVAL = 1;
    localparam int F_RXIE = 2;
    localparam int F_TXIE = 3;
    localparam int F_TXRQ = 4;
    localparam int F_CPUUPD = 5;
    localparam int F_INTPND = 6;
    localparam int F_NEWDAT = 7;
    localparam int F_MSGLST = 8;

    typedef enum logic [1:0] {
        t_idle_s,
        t_exec_s,
        t_out_s
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic execute;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic busy;
    } t_stat;

    function automatic logic [63:0] keep_bytes(input logic [63:0] d, input logic [3:0] len);
        logic [63:0] m;
        m = '0;
        for (int b = 0; b < 8; b++) begin
            if (len > 4'(b)) m[b*8 +: 8] = 8'hff;
        end
        return d & m;
    endfunction

endpackage

// ----- design/can_message_object_controller_core.sv -----
// top level of the message object controller
// channel | direction | handshake
// item    | in        | i_valid / o_ready
// result  | out       | o_valid / i_ready
// config  | in        | i_cfg_we, no wait
// an item is captured, then executed over the object table
// the result is held in an output register until transferred; the next item
// is accepted in the cycle the result is taken
// synchronous active-low reset clears the object table and all flags
module can_message_object_controller_core import cmo_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic        i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_opcode,
    input  logic [3:0]  i_object_index,
    input  logic [10:0] i_frame_id,
    input  logic [3:0]  i_frame_length,
    input  logic [63:0] i_frame_data,
    input  logic [5:0]  i_control_bits,
    input  logic [2:0]  i_clear_mask,
    input  logic        i_bus_off,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_status,
    output logic        o_tx_start,
    output logic [10:0] o_out_id,
    output logic [3:0]  o_out_length,
    output logic [63:0] o_out_data,
    output logic [8:0]  o_out_flags,
    output logic        o_status_irq,
    output logic        o_msg_irq_valid,
    output logic [3:0]  o_msg_irq_object,
    output logic        o_rx_ok
);
    logic r_init, r_enable, r_master;
    t_cmd  cmd;
    t_stat stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init <= 1'b0;
            r_enable <= 1'b0;
            r_master <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_INIT:   r_init <= i_cfg_data;
                CFG_ENABLE: r_enable <= i_cfg_data;
                CFG_MASTER: r_master <= i_cfg_data;
                default: ;
            endcase
        end
    end

    cmo_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .o_valid(o_valid), .i_ready(i_ready), .i_stat(stat), .o_cmd(cmd)
    );

    cmo_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .o_stat(stat),
        .i_cfg_init(r_init), .i_cfg_enable(r_enable), .i_cfg_master(r_master),
        .i_opcode(i_opcode), .i_object_index(i_object_index), .i_frame_id(i_frame_id),
        .i_frame_length(i_frame_length), .i_frame_data(i_frame_data),
        .i_control_bits(i_control_bits), .i_clear_mask(i_clear_mask),
        .i_bus_off(i_bus_off), .o_status(o_status), .o_tx_start(o_tx_start),
        .o_out_id(o_out_id), .o_out_length(o_out_length), .o_out_data(o_out_data),
        .o_out_flags(o_out_flags), .o_status_irq(o_status_irq),
        .o_msg_irq_valid(o_msg_irq_valid), .o_msg_irq_object(o_msg_irq_object),
        .o_rx_ok(o_rx_ok)
    );
endmodule

// ----- design/cmo_ctrl.sv -----
// controller: sequences capture, execute and result hand-off
module cmo_ctrl import cmo_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    output logic  o_valid,
    input  logic  i_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);
    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= t_idle_s;
        else r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            t_idle_s: if (i_valid) n_state = t_exec_s;
            t_exec_s: n_state = t_out_s;
            t_out_s:  if (i_ready) n_state = i_valid ? t_exec_s : t_idle_s;
            default:  n_state = t_idle_s;
        endcase
    end

    always_comb begin
        o_ready = 1'b0;
        o_valid = 1'b0;
        o_cmd = '0;
        unique case (r_state)
            t_idle_s: begin
                o_ready = 1'b1;
                o_cmd.capture = i_valid;
            end
            t_exec_s: o_cmd.execute = 1'b1;
            t_out_s: begin
                o_valid = 1'b1;
                // next item may enter as the result leaves
                o_ready = i_ready;
                o_cmd.capture = i_ready & i_valid;
            end
            default: ;
        endcase
    end

    a_exec_from_capture: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.capture |=> r_state == t_exec_s) else $error("capture not followed by execute");
    a_exec_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.execute |=> o_valid) else $error("result not shown after execute");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid) else $error("result dropped");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.execute |-> i_stat.busy) else $error("execute without captured item");
endmodule

// ----- design/cmo_datapath.sv -----
// datapath: object table, rx match, tx scan and interrupt search
module cmo_datapath import cmo_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    output t_stat       o_stat,
    input  logic        i_cfg_init,
    input  logic        i_cfg_enable,
    input  logic        i_cfg_master,
    input  logic [2:0]  i_opcode,
    input  logic [3:0]  i_object_index,
    input  logic [10:0] i_frame_id,
    input  logic [3:0]  i_frame_length,
    input  logic [63:0] i_frame_data,
    input  logic [5:0]  i_control_bits,
    input  logic [2:0]  i_clear_mask,
    input  logic        i_bus_off,
    output logic [1:0]  o_status,
    output logic        o_tx_start,
    output logic [10:0] o_out_id,
    output logic [3:0]  o_out_length,
    output logic [63:0] o_out_data,
    output logic [8:0]  o_out_flags,
    output logic        o_status_irq,
    output logic        o_msg_irq_valid,
    output logic [3:0]  o_msg_irq_object,
    output logic        o_rx_ok
);
    logic [10:0] r_ids [NUM_OBJECTS];
    logic [8:0]  r_flags [NUM_OBJECTS];
    logic [63:0] r_data [NUM_OBJECTS];
    logic [3:0]  r_lens [NUM_OBJECTS];
    logic r_tx_pending, r_status_update, r_received_ok, r_busy;
    logic [IDX_W-1:0] r_last_tx;

    // captured item
    logic [2:0]  r_op;
    logic [3:0]  r_idx, r_len;
    logic [10:0] r_fid;
    logic [63:0] r_dat;
    logic [5:0]  r_ctrl;
    logic [2:0]  r_clr;
    logic        r_boff;

    assign o_stat.busy = r_busy;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op <= i_opcode;
            r_idx <= i_object_index;
            r_fid <= i_frame_id;
            r_len <= (i_frame_length > 4'd8) ? 4'd8 : i_frame_length;
            r_dat <= i_frame_data;
            r_ctrl <= i_control_bits;
            r_clr <= i_clear_mask;
            r_boff <= i_bus_off;
        end
    end

    logic addr_ok;
    logic [IDX_W-1:0] aidx;
    assign addr_ok = 32'(r_idx) < NUM_OBJECTS;
    assign aidx = IDX_W'(r_idx);

    // rx match and irq-pending search
    logic rx_pend, match_hit;
    logic [IDX_W-1:0] match_i;
    always_comb begin
        rx_pend = 1'b0;
        match_hit = 1'b0;
        match_i = '0;
        for (int i = NUM_OBJECTS - 1; i >= 0; i--) begin
            if (!r_flags[i][F_DIR] && r_flags[i][F_INTPND]) rx_pend = 1'b1;
            if (r_ids[i] == r_fid && !r_flags[i][F_DIR] && r_flags[i][F_MSGVAL]) begin
                match_hit = 1'b1;
                match_i = IDX_W'(i);
            end
        end
    end

    // flags after the rx or tx-done part of the item
    logic [8:0] fl_mid [NUM_OBJECTS];
    logic       rx_do, txd_do, pend_mid;
    assign rx_do = r_op == OP_RX && !i_cfg_init && !rx_pend;
    assign txd_do = r_op == OP_TX_DONE && !i_cfg_init && r_tx_pending;
    always_comb begin
        for (int i = 0; i < NUM_OBJECTS; i++) begin
            fl_mid[i] = r_flags[i];
            if (rx_do && match_hit && match_i == IDX_W'(i)) begin
                if (r_flags[i][F_RXIE]) fl_mid[i][F_INTPND] = 1'b1;
                if (r_flags[i][F_NEWDAT]) fl_mid[i][F_MSGLST] = 1'b1;
                fl_mid[i][F_NEWDAT] = 1'b1;
            end
            if (txd_do && r_last_tx == IDX_W'(i)) begin
                fl_mid[i][F_TXRQ] = 1'b0;
                if (r_flags[i][F_TXIE]) fl_mid[i][F_INTPND] = 1'b1;
            end
        end
        pend_mid = r_tx_pending && !txd_do;
    end

    logic tx_hit, irq_hit;
    logic [IDX_W-1:0] tx_i, irq_i;
    always_comb begin
        tx_hit = 1'b0;
        tx_i = '0;
        irq_hit = 1'b0;
        irq_i = '0;
        for (int i = NUM_OBJECTS - 1; i >= 0; i--) begin
            if (fl_mid[i][F_TXRQ] && fl_mid[i][F_DIR] && fl_mid[i][F_MSGVAL]
                && !fl_mid[i][F_CPUUPD]) begin
                tx_hit = 1'b1;
                tx_i = IDX_W'(i);
            end
            if (fl_mid[i][F_INTPND] && fl_mid[i][F_MSGVAL]) begin
                irq_hit = 1'b1;
                irq_i = IDX_W'(i);
            end
        end
    end

    logic scan_op, tx_go, irq_en;
    assign scan_op = r_op == OP_RX || r_op == OP_TX_DONE || r_op == OP_SERVICE;
    assign tx_go = r_busy && scan_op && !i_cfg_init && !pend_mid && tx_hit;
    assign irq_en = r_op == OP_SERVICE && !i_cfg_init && i_cfg_enable && i_cfg_master;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_OBJECTS; i++) begin
                r_ids[i] <= '0;
                r_flags[i] <= '0;
                r_data[i] <= '0;
                r_lens[i] <= '0;
            end
            r_tx_pending <= 1'b0;
            r_last_tx <= '0;
            r_status_update <= 1'b0;
            r_received_ok <= 1'b0;
            r_busy <= 1'b0;
        end else begin
            if (i_cmd.capture) r_busy <= 1'b1;
            else if (i_cmd.execute) r_busy <= 1'b0;
            if (i_cmd.execute) begin
                for (int i = 0; i < NUM_OBJECTS; i++) r_flags[i] <= fl_mid[i];
                r_tx_pending <= pend_mid || tx_go;
                if (tx_go) r_last_tx <= tx_i;
                unique case (r_op)
                    OP_WR_CTRL: if (addr_ok) begin
                        r_ids[aidx] <= r_fid;
                        r_flags[aidx] <= {r_flags[aidx][8:6], r_ctrl};
                    end
                    OP_WR_DATA: if (addr_ok) begin
                        r_lens[aidx] <= r_len;
                        r_data[aidx] <= keep_bytes(r_dat, r_len);
                    end
                    OP_CLEAR: if (addr_ok) begin
                        r_flags[aidx] <= r_flags[aidx] & ~{r_clr[2], r_clr[1], r_clr[0], 6'b0};
                    end
                    OP_RX: if (rx_do) begin
                        r_received_ok <= 1'b1;
                        r_status_update <= 1'b1;
                        if (match_hit) begin
                            r_lens[match_i] <= r_len;
                            r_data[match_i] <= keep_bytes(r_dat, r_len);
                        end
                    end
                    OP_SERVICE: if (irq_en && (r_status_update || r_boff))
                        r_status_update <= 1'b0;
                    default: ;
                endcase
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.execute) begin
            o_status <= ST_OK;
            if (r_op == OP_RX) begin
                if (i_cfg_init) o_status <= ST_REF_INIT;
                else if (rx_pend) o_status <= ST_REF_IRQ;
                else if (!match_hit) o_status <= ST_NO_MATCH;
            end
            o_tx_start <= tx_go;
            o_out_id <= '0;
            o_out_length <= '0;
            o_out_data <= '0;
            o_out_flags <= '0;
            if (tx_go) begin
                o_out_id <= r_ids[tx_i];
                o_out_length <= r_lens[tx_i];
                o_out_data <= r_data[tx_i];
            end else if (r_op == OP_READ && addr_ok) begin
                o_out_id <= r_ids[aidx];
                o_out_length <= r_lens[aidx];
                o_out_data <= r_data[aidx];
                o_out_flags <= r_flags[aidx];
            end
            o_status_irq <= irq_en && (r_status_update || r_boff);
            o_msg_irq_valid <= irq_en && irq_hit;
            o_msg_irq_object <= (irq_en && irq_hit) ? 4'(irq_i) : 4'd0;
            o_rx_ok <= r_received_ok || rx_do;
        end
    end
endmodule

// ----- sim/cmo_checker.sv -----
// checker for the message object controller: table prediction and result comparison
`timescale 1ns / 100ps

module cmo_checker import cmo_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic        i_cfg_data,
    input  logic        i_valid,
    input  logic        i_item_ready,
    input  logic [2:0]  i_opcode,
    input  logic [3:0]  i_object_index,
    input  logic [10:0] i_frame_id,
    input  logic [3:0]  i_frame_length,
    input  logic [63:0] i_frame_data,
    input  logic [5:0]  i_control_bits,
    input  logic [2:0]  i_clear_mask,
    input  logic        i_bus_off,
    input  logic        i_res_valid,
    input  logic        i_ready,
    input  logic [1:0]  i_status,
    input  logic        i_tx_start,
    input  logic [10:0] i_out_id,
    input  logic [3:0]  i_out_length,
    input  logic [63:0] i_out_data,
    input  logic [8:0]  i_out_flags,
    input  logic        i_status_irq,
    input  logic        i_msg_irq_valid,
    input  logic [3:0]  i_msg_irq_object,
    input  logic        i_rx_ok,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_results_seen
);

    typedef struct packed {
        logic [1:0]  status;
        logic        tx_start;
        logic [10:0] id;
        logic [3:0]  len;
        logic [63:0] data;
        logic [8:0]  flags;
        logic        status_irq;
        logic        msg_irq_valid;
        logic [3:0]  msg_irq_object;
        logic        rx_ok;
    } t_result;

    logic [10:0] obj_id   [NUM_OBJECTS];
    logic [8:0]  obj_flag [NUM_OBJECTS];
    logic [63:0] obj_data [NUM_OBJECTS];
    logic [3:0]  obj_len  [NUM_OBJECTS];
    logic        tx_busy, stat_upd, rx_seen;
    logic [3:0]  tx_obj;
    logic        cfg_init, cfg_en, cfg_master;

    t_result expected_results[$];
    int      fails, seen;

    function automatic logic [63:0] trim_data(input logic [63:0] d, input logic [3:0] len);
        if (len >= 4'd8)
            return d;
        return d & ((64'd1 << (8 * len)) - 64'd1);
    endfunction

    // lowest eligible transmit object, once at a time
    task automatic start_tx(inout t_result r);
        logic [8:0] f;
        if (cfg_init || tx_busy)
            return;
        for (int i = 0; i < NUM_OBJECTS; i++) begin
            f = obj_flag[i];
            if (f[F_TXRQ] && f[F_DIR] && f[F_MSGVAL] && !f[F_CPUUPD]) begin
                tx_busy = 1'b1;
                tx_obj = 4'(i);
                r.tx_start = 1'b1;
                r.id = obj_id[i];
                r.len = obj_len[i];
                r.data = obj_data[i];
                return;
            end
        end
    endtask

    task automatic predict_item(output t_result r);
        logic [3:0] len;
        logic [8:0] f;
        logic       blocked;
        logic       hit;
        r = '0;
        len = (i_frame_length > 4'd8) ? 4'd8 : i_frame_length;
        case (i_opcode)
            OP_WR_CTRL: begin
                obj_id[i_object_index] = i_frame_id;
                obj_flag[i_object_index] = {obj_flag[i_object_index][8:6], i_control_bits};
            end
            OP_WR_DATA: begin
                obj_len[i_object_index] = len;
                obj_data[i_object_index] = trim_data(i_frame_data, len);
            end
            OP_CLEAR: begin
                if (i_clear_mask[0]) obj_flag[i_object_index][F_INTPND] = 1'b0;
                if (i_clear_mask[1]) obj_flag[i_object_index][F_NEWDAT] = 1'b0;
                if (i_clear_mask[2]) obj_flag[i_object_index][F_MSGLST] = 1'b0;
            end
            OP_READ: begin
                r.id = obj_id[i_object_index];
                r.len = obj_len[i_object_index];
                r.data = obj_data[i_object_index];
                r.flags = obj_flag[i_object_index];
            end
            OP_RX: begin
                blocked = 1'b0;
                for (int i = 0; i < NUM_OBJECTS; i++)
                    if (!obj_flag[i][F_DIR] && obj_flag[i][F_INTPND]) blocked = 1'b1;
                if (cfg_init) begin
                    r.status = ST_REF_INIT;
                end else if (blocked) begin
                    r.status = ST_REF_IRQ;
                end else begin
                    rx_seen = 1'b1;
                    stat_upd = 1'b1;
                    r.status = ST_NO_MATCH;
                    hit = 1'b0;
                    for (int i = 0; i < NUM_OBJECTS; i++) begin
                        f = obj_flag[i];
                        if (!hit && obj_id[i] == i_frame_id && !f[F_DIR] && f[F_MSGVAL]) begin
                            hit = 1'b1;
                            if (f[F_RXIE]) f[F_INTPND] = 1'b1;
                            if (f[F_NEWDAT]) f[F_MSGLST] = 1'b1;
                            f[F_NEWDAT] = 1'b1;
                            obj_flag[i] = f;
                            obj_len[i] = len;
                            obj_data[i] = trim_data(i_frame_data, len);
                            r.status = ST_OK;
                        end
                    end
                end
                start_tx(r);
            end
            OP_TX_DONE: begin
                if (!cfg_init && tx_busy) begin
                    obj_flag[tx_obj][F_TXRQ] = 1'b0;
                    if (obj_flag[tx_obj][F_TXIE]) obj_flag[tx_obj][F_INTPND] = 1'b1;
                    tx_busy = 1'b0;
                end
                start_tx(r);
            end
            OP_SERVICE: begin
                start_tx(r);
                if (!cfg_init && cfg_en && cfg_master) begin
                    if (stat_upd || i_bus_off) begin
                        stat_upd = 1'b0;
                        r.status_irq = 1'b1;
                    end
                    for (int i = NUM_OBJECTS - 1; i >= 0; i--) begin
                        if (obj_flag[i][F_INTPND] && obj_flag[i][F_MSGVAL]) begin
                            r.msg_irq_valid = 1'b1;
                            r.msg_irq_object = 4'(i);
                        end
                    end
                end
            end
            default: ;
        endcase
        r.rx_ok = rx_seen;
    endtask

    always @(posedge i_clk) begin
        t_result got, want;
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_OBJECTS; i++) begin
                obj_id[i] = '0;
                obj_flag[i] = '0;
                obj_data[i] = '0;
                obj_len[i] = '0;
            end
            tx_busy = 1'b0;
            tx_obj = '0;
            stat_upd = 1'b0;
            rx_seen = 1'b0;
            cfg_init = 1'b0;
            cfg_en = 1'b0;
            cfg_master = 1'b0;
            expected_results.delete();
            fails = 0;
            seen = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_INIT:   cfg_init = i_cfg_data;
                    CFG_ENABLE: cfg_en = i_cfg_data;
                    CFG_MASTER: cfg_master = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_res_valid && i_ready) begin
                got = {i_status, i_tx_start, i_out_id, i_out_length, i_out_data, i_out_flags,
                       i_status_irq, i_msg_irq_valid, i_msg_irq_object, i_rx_ok};
                seen++;
                if (expected_results.size() == 0) begin
                    fails++;
                    if (fails <= 10)
                        $display("unexpected result transfer: %h", got);
                end else begin
                    want = expected_results.pop_front();
                    if (got.status !== want.status || got.tx_start !== want.tx_start ||
                        got.id !== want.id || got.len !== want.len ||
                        got.data !== want.data || got.flags !== want.flags ||
                        got.status_irq !== want.status_irq ||
                        got.msg_irq_valid !== want.msg_irq_valid ||
                        got.msg_irq_object !== want.msg_irq_object ||
                        got.rx_ok !== want.rx_ok) begin
                        fails++;
                        if (fails <= 10) begin
                            $display("result %0d wrong", seen);
                            $display("  exp st=%0d tx=%b id=%h len=%0d data=%h fl=%h si=%b mv=%b mo=%0d rx=%b",
                                     want.status, want.tx_start, want.id, want.len, want.data,
                                     want.flags, want.status_irq, want.msg_irq_valid,
                                     want.msg_irq_object, want.rx_ok);
                            $display("  got st=%0d tx=%b id=%h len=%0d data=%h fl=%h si=%b mv=%b mo=%0d rx=%b",
                                     got.status, got.tx_start, got.id, got.len, got.data,
                                     got.flags, got.status_irq, got.msg_irq_valid,
                                     got.msg_irq_object, got.rx_ok);
                        end
                    end
                end
            end
            if (i_valid && i_item_ready) begin
                predict_item(want);
                expected_results.push_back(want);
            end
        end
        o_fail_count <= fails;
        o_pending <= expected_results.size();
        o_results_seen <= seen;
    end

endmodule

// ----- sim/tb_can_message_object_controller_core.sv -----
// testbench top: stimulus, idling phases and verdict for the message object controller
`timescale 1ns / 100ps

module tb_can_message_object_controller_core;
    import cmo_pkg::*;

    localparam logic [2:0] OP_NONE = 3'd7;
    localparam int         SETTLE  = 6;

    logic        i_clk, i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_index;
    logic        i_cfg_data;
    logic        i_valid, o_ready;
    logic [2:0]  i_opcode;
    logic [3:0]  i_object_index;
    logic [10:0] i_frame_id;
    logic [3:0]  i_frame_length;
    logic [63:0] i_frame_data;
    logic [5:0]  i_control_bits;
    logic [2:0]  i_clear_mask;
    logic        i_bus_off;
    logic        o_valid, i_ready;
    logic [1:0]  o_status;
    logic        o_tx_start;
    logic [10:0] o_out_id;
    logic [3:0]  o_out_length;
    logic [63:0] o_out_data;
    logic [8:0]  o_out_flags;
    logic        o_status_irq, o_msg_irq_valid;
    logic [3:0]  o_msg_irq_object;
    logic        o_rx_ok;

    int fail_count, pending, results_seen;
    int send_idle_pct, recv_stall_pct;
    int items_sent;
    logic [10:0] id_pool[8];

    can_message_object_controller_core uut (.*);

    cmo_checker u_checker (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_index, .i_cfg_data,
        .i_valid, .i_item_ready(o_ready), .i_opcode, .i_object_index, .i_frame_id,
        .i_frame_length, .i_frame_data, .i_control_bits, .i_clear_mask, .i_bus_off,
        .i_res_valid(o_valid), .i_ready, .i_status(o_status), .i_tx_start(o_tx_start),
        .i_out_id(o_out_id), .i_out_length(o_out_length), .i_out_data(o_out_data),
        .i_out_flags(o_out_flags), .i_status_irq(o_status_irq),
        .i_msg_irq_valid(o_msg_irq_valid), .i_msg_irq_object(o_msg_irq_object),
        .i_rx_ok(o_rx_ok), .o_fail_count(fail_count), .o_pending(pending),
        .o_results_seen(results_seen)
    );

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // one item; valid is lowered only where a gap falls before it
    task automatic send_item(input logic [2:0] op, input logic [3:0] idx, input logic [10:0] id,
                             input logic [3:0] len, input logic [63:0] d, input logic [5:0] ctrl,
                             input logic [2:0] mask, input logic boff);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct && gap < 40) gap++;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_opcode <= op;
        i_object_index <= idx;
        i_frame_id <= id;
        i_frame_length <= len;
        i_frame_data <= d;
        i_control_bits <= ctrl;
        i_clear_mask <= mask;
        i_bus_off <= boff;
        do @(posedge i_clk); while (!o_ready);
        items_sent++;
    endtask

    task automatic drain;
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic val);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic random_item;
        logic [2:0]  op;
        logic [5:0]  ctrl;
        logic [10:0] id;
        logic [2:0]  mask;
        int          r;
        r = $urandom_range(99);
        if (r < 12) op = OP_WR_CTRL;
        else if (r < 20) op = OP_WR_DATA;
        else if (r < 35) op = OP_CLEAR;
        else if (r < 45) op = OP_READ;
        else if (r < 70) op = OP_RX;
        else if (r < 82) op = OP_TX_DONE;
        else if (r < 97) op = OP_SERVICE;
        else op = OP_NONE;
        id = ($urandom_range(99) < 75) ? id_pool[$urandom_range(7)] : 11'($urandom);
        r = $urandom_range(99);
        // mostly sensible receive or transmit objects, some random control
        if (r < 35) ctrl = {1'b0, 1'b0, 1'b0, $urandom_range(1) == 1, 1'b1, 1'b0};
        else if (r < 70) ctrl = {($urandom_range(9) == 0), 1'b1, ($urandom_range(1) == 1),
                                 1'b0, 1'b1, 1'b1};
        else ctrl = 6'($urandom);
        mask = ($urandom_range(99) < 70) ? (3'($urandom) | 3'b001) : 3'($urandom);
        send_item(op, 4'($urandom), id, 4'($urandom), {$urandom, $urandom}, ctrl, mask,
                  1'($urandom));
    endtask

    initial begin
        logic [2:0] cfg_plan[6];
        int idle_plan[4][2];
        cfg_plan = '{3'b011, 3'b000, 3'b111, 3'b010, 3'b001, 3'b011};
        idle_plan = '{'{0, 0}, '{61, 0}, '{0, 61}, '{9, 9}};
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = 1'b0;
        i_valid = 1'b0;
        i_ready = 1'b0;
        i_opcode = '0;
        i_object_index = '0;
        i_frame_id = '0;
        i_frame_length = '0;
        i_frame_data = '0;
        i_control_bits = '0;
        i_clear_mask = '0;
        i_bus_off = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        items_sent = 0;
        foreach (id_pool[k]) id_pool[k] = 11'($urandom);
        id_pool[0] = 11'h7ff;
        id_pool[1] = 11'h000;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: matching, overwrite, refusals, transmit flow, reads
        send_item(OP_WR_CTRL, 4'd0, 11'h123, 0, 0, 6'b000110, 0, 0);
        send_item(OP_WR_CTRL, 4'd1, 11'h123, 0, 0, 6'b000010, 0, 0);
        send_item(OP_WR_CTRL, 4'd2, 11'h456, 0, 0, 6'b011011, 0, 0);
        send_item(OP_WR_DATA, 4'd2, 0, 4'd15, '1, 0, 0, 0);
        send_item(OP_WR_CTRL, 4'd3, 11'h7ff, 0, 0, 6'b110011, 0, 0);
        send_item(OP_WR_CTRL, 4'd15, 11'h000, 0, 0, 6'b111111, 0, 0);
        send_item(OP_RX, 0, 11'h123, 4'd3, 64'h0123_4567_89ab_cdef, 0, 0, 0);
        send_item(OP_RX, 0, 11'h123, 4'd8, '1, 0, 0, 0);
        send_item(OP_SERVICE, 0, 0, 0, 0, 0, 0, 1'b1);
        send_item(OP_CLEAR, 4'd0, 0, 0, 0, 0, 3'b001, 0);
        send_item(OP_RX, 0, 11'h123, 4'd0, '1, 0, 0, 0);
        send_item(OP_CLEAR, 4'd0, 0, 0, 0, 0, 3'b001, 0);
        send_item(OP_RX, 0, 11'h555, 4'd9, '1, 0, 0, 0);
        send_item(OP_TX_DONE, 0, 0, 0, 0, 0, 0, 0);
        send_item(OP_TX_DONE, 0, 0, 0, 0, 0, 0, 0);
        send_item(OP_READ, 4'd0, 0, 0, 0, 0, 0, 0);
        send_item(OP_READ, 4'd2, 0, 0, 0, 0, 0, 0);
        send_item(OP_READ, 4'd15, 0, 0, 0, 0, 0, 0);
        send_item(OP_NONE, 4'd15, '1, 4'd15, '1, '1, '1, 1'b1);
        send_item(OP_CLEAR, 4'd0, 0, 0, 0, 0, 3'b111, 0);
        send_item(OP_WR_DATA, 4'd5, 0, 4'd0, '1, 0, 0, 0);
        send_item(OP_READ, 4'd5, 0, 0, 0, 0, 0, 0);
        drain();

        for (int p = 0; p < 6; p++) begin
            write_reg(CFG_INIT, cfg_plan[p][2]);
            write_reg(CFG_ENABLE, cfg_plan[p][1]);
            write_reg(CFG_MASTER, cfg_plan[p][0]);
            send_idle_pct = idle_plan[p % 4][0];
            recv_stall_pct = idle_plan[p % 4][1];
            if (p == 0) send_item(OP_SERVICE, 0, 0, 0, 0, 0, 0, 1'b1);
            for (int n = 0; n < 150; n++) begin
                random_item();
                // hold off until the pipeline is empty once per phase
                if (n == 75) drain();
            end
            drain();
        end
        recv_stall_pct = 0;

        $display("sent %0d items, %0d results compared, over six register settings",
                 items_sent, results_seen);
        $display("and four sender/receiver idling mixes");
        if (fail_count == 0)
            $display("can_message_object_controller_core: match");
        else
            $display("can_message_object_controller_core: mismatch");
        $finish;
    end

    initial begin
        #50_000_000;
        $display("can_message_object_controller_core: mismatch");
        $finish;
    end

endmodule
